FILE: hdl/dffft_pkg.sv
// Shared types and constants of the DALI forward frame transmitter.
package dffft_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_POLARITY     = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_LEVEL_ADDR   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_COMMAND_ADDR = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_OFF_CMD      = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_ON_CMD       = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_LEVEL_ADDR   = 8'd254;
  localparam logic [7:0] RST_COMMAND_ADDR = 8'd255;
  localparam logic [7:0] RST_OFF_CMD      = 8'd0;
  localparam logic [7:0] RST_ON_CMD       = 8'd5;

  // Request kinds
  localparam logic KIND_RAW   = 1'b0;
  localparam logic KIND_LEVEL = 1'b1;

  // Level scaling and thresholds
  localparam logic [7:0]  PCT_MAX   = 8'd100;
  localparam logic [7:0]  LEVEL_LOW = 8'd25;
  localparam logic [7:0]  LEVEL_HI  = 8'd250;
  localparam logic [7:0]  LEVEL_OFF = 8'd0;
  localparam logic [7:0]  LEVEL_ON  = 8'd255;
  // x/100 == (x*DIV100_MUL) >> DIV100_SH for x up to 255*100
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int unsigned DIV100_SH  = 19;

  // Frame serialization: start bit plus 16 data bits, two halves each, then stop
  localparam int unsigned FRAME_BITS = 17;
  localparam int unsigned FRAME_ITEMS = 2 * FRAME_BITS + 1;
  localparam int unsigned CNT_W = $clog2(FRAME_ITEMS);
  localparam logic [CNT_W-1:0] STOP_ITEM = CNT_W'(FRAME_ITEMS - 1);

  // Frame queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } frame_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

endpackage

FILE: hdl/dffft_front.sv
// Front end: configuration registers, request decoding and level tracking.
module dffft_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dffft_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic                          kind,
  input  logic [7:0]                    address_byte,
  input  logic [7:0]                    data_byte,
  input  logic [7:0]                    level_percent,
  input  dffft_pkg::qstat_t             qstat,
  output logic                          q_push,
  output dffft_pkg::frame_t             q_frame,
  output logic                          polarity_inverted
);

  logic [7:0]  broadcast_level_address;
  logic [7:0]  broadcast_command_address;
  logic [7:0]  off_command;
  logic [7:0]  on_command;
  logic [7:0]  current_level;
  logic [7:0]  current_level_next;
  logic        accept;
  logic        send;
  logic [15:0] pct_x255;
  logic [28:0] prod;
  logic [7:0]  scaled;

  assign cfg_ready = 1'b1;
  assign full      = qstat.full;
  assign accept    = push && !qstat.full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      polarity_inverted         <= 1'b0;
      broadcast_level_address   <= dffft_pkg::RST_LEVEL_ADDR;
      broadcast_command_address <= dffft_pkg::RST_COMMAND_ADDR;
      off_command               <= dffft_pkg::RST_OFF_CMD;
      on_command                <= dffft_pkg::RST_ON_CMD;
    end else if (cfg_valid) begin
      case (cfg_index)
        dffft_pkg::CFG_POLARITY:     polarity_inverted <= cfg_data[0];
        dffft_pkg::CFG_LEVEL_ADDR:   broadcast_level_address <= cfg_data;
        dffft_pkg::CFG_COMMAND_ADDR: broadcast_command_address <= cfg_data;
        dffft_pkg::CFG_OFF_CMD:      off_command <= cfg_data;
        dffft_pkg::CFG_ON_CMD:       on_command <= cfg_data;
        default: ;
      endcase
    end
  end

  // Percent to level: pct*255, then divide by 100 through a reciprocal
  assign pct_x255 = {level_percent, 8'd0} - {8'd0, level_percent};
  assign prod     = 29'(pct_x255) * 29'(dffft_pkg::DIV100_MUL);
  assign scaled   = prod[dffft_pkg::DIV100_SH +: 8];

  // Request classification
  always_comb begin
    send               = 1'b0;
    q_frame.first      = address_byte;
    q_frame.second     = data_byte;
    current_level_next = current_level;
    if (kind == dffft_pkg::KIND_RAW) begin
      send = 1'b1;
    end else if (level_percent <= dffft_pkg::PCT_MAX && scaled != current_level) begin
      send = 1'b1;
      if (scaled < dffft_pkg::LEVEL_LOW) begin
        q_frame.first      = broadcast_command_address;
        q_frame.second     = off_command;
        current_level_next = dffft_pkg::LEVEL_OFF;
      end else if (scaled > dffft_pkg::LEVEL_HI) begin
        q_frame.first      = broadcast_command_address;
        q_frame.second     = on_command;
        current_level_next = dffft_pkg::LEVEL_ON;
      end else begin
        q_frame.first      = broadcast_level_address;
        q_frame.second     = scaled;
        current_level_next = scaled;
      end
    end
  end

  assign q_push = accept && send;

  // Stored level
  always_ff @(posedge clk) begin
    if (rst) begin
      current_level <= 8'd0;
    end else if (accept) begin
      current_level <= current_level_next;
    end
  end

endmodule

FILE: hdl/dffft_queue.sv
// Short frame queue between request decoding and serialization.
module dffft_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  dffft_pkg::frame_t wr_frame,
  input  logic              rd_en,
  output dffft_pkg::frame_t rd_frame,
  output dffft_pkg::qstat_t qstat
);

  dffft_pkg::frame_t          slots [dffft_pkg::QDEPTH];
  logic [dffft_pkg::QAW-1:0]  wr_ptr;
  logic [dffft_pkg::QAW-1:0]  rd_ptr;
  logic [dffft_pkg::QAW:0]    count;
  logic                       do_wr;
  logic                       do_rd;

  assign qstat.full     = (count == (dffft_pkg::QAW+1)'(dffft_pkg::QDEPTH));
  assign qstat.nonempty = (count != '0);
  assign do_wr          = wr_en && !qstat.full;
  assign do_rd          = rd_en && qstat.nonempty;
  assign rd_frame       = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_frame;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == dffft_pkg::QAW'(dffft_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == dffft_pkg::QAW'(dffft_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/dffft_serializer.sv
// Back end: Manchester serializer of queued frames into half-bit results.
module dffft_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              polarity_inverted,
  input  dffft_pkg::qstat_t qstat,
  input  dffft_pkg::frame_t q_frame,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic              line_level,
  output logic              stop_period,
  output logic              last
);

  logic                          busy;
  logic                          out_valid;
  logic [dffft_pkg::CNT_W-1:0]   cnt;
  logic [dffft_pkg::FRAME_BITS-1:0] word;
  logic                          advance;
  logic                          at_stop;
  logic [4:0]                    bit_idx;
  logic                          bit_val;
  logic                          item_level;

  assign empty   = !out_valid;
  assign advance = !out_valid || pop;
  assign at_stop = (cnt == dffft_pkg::STOP_ITEM);
  assign q_pop   = qstat.nonempty && (!busy || (advance && at_stop));

  // Half-bit level of the current item
  assign bit_idx = 5'(dffft_pkg::FRAME_BITS - 1) - 5'(cnt[dffft_pkg::CNT_W-1:1]);
  assign bit_val = word[bit_idx];
  always_comb begin
    if (at_stop) begin
      item_level = ~polarity_inverted;
    end else begin
      item_level = (~bit_val ^ polarity_inverted) ^ cnt[0];
    end
  end

  // Frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      cnt  <= '0;
      word <= {1'b1, q_frame.first, q_frame.second};
    end else if (busy && advance) begin
      if (at_stop) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && busy) begin
      line_level  <= item_level;
      stop_period <= at_stop;
      last        <= at_stop;
    end
  end

endmodule

FILE: hdl/dali_forward_frame_transmitter_unit.sv
// A frame's first half-bit result passes the frame queue, the serializer's word register
// and its output register. Throughput: one result per cycle while pop is held; a frame
//   is 35 results, frames follow gap-free, set by the serializer's half-bit counter.
// Requests are taken while the two-entry frame queue has room.
// Reset (synchronous, rst high) clears queue, serializer, stored level and registers.
module dali_forward_frame_transmitter_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dffft_pkg::CFG_IW-1:0] cfg_index,
  input  logic [7:0]                   cfg_data,
  input  logic                         push,
  output logic                         full,
  input  logic                         kind,
  input  logic [7:0]                   address_byte,
  input  logic [7:0]                   data_byte,
  input  logic [7:0]                   level_percent,
  output logic                         empty,
  input  logic                         pop,
  output logic                         line_level,
  output logic                         stop_period,
  output logic                         last
);

  dffft_pkg::qstat_t qstat;
  dffft_pkg::frame_t wr_frame;
  dffft_pkg::frame_t rd_frame;
  logic              q_push;
  logic              q_pop;
  logic              polarity_inverted;

  dffft_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .push              (push),
    .full              (full),
    .kind              (kind),
    .address_byte      (address_byte),
    .data_byte         (data_byte),
    .level_percent     (level_percent),
    .qstat             (qstat),
    .q_push            (q_push),
    .q_frame           (wr_frame),
    .polarity_inverted (polarity_inverted)
  );

  dffft_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_frame (wr_frame),
    .rd_en    (q_pop),
    .rd_frame (rd_frame),
    .qstat    (qstat)
  );

  dffft_serializer u_ser (
    .clk               (clk),
    .rst               (rst),
    .polarity_inverted (polarity_inverted),
    .qstat             (qstat),
    .q_frame           (rd_frame),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .line_level        (line_level),
    .stop_period       (stop_period),
    .last              (last)
  );

endmodule

FILE: hdl/dffft_checker.sv
// Port-level checks of the transmitter, bound to the top level.
module dffft_checker (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input logic line_level,
  input logic stop_period,
  input logic last
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // Only the stop period closes a frame
  a_last_stop: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last == stop_period))
    else $error("last and stop_period disagree");

  // A waiting result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(line_level) && $stable(stop_period) && $stable(last)))
    else $error("waiting result changed");

endmodule

bind dali_forward_frame_transmitter_unit dffft_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .line_level  (line_level),
  .stop_period (stop_period),
  .last        (last)
);

FILE: tb/tb_dali_forward_frame_transmitter.sv
`timescale 1ns / 100ps
// Self-checking testbench of the DALI forward frame transmitter: half-bit levels per request.
module tb;

  // One serialized half-bit (or the stop period) as seen on the result ports
  typedef struct packed {
    logic line_level;
    logic stop_period;
    logic last;
  } half_bit_t;

  // Settling wait once every expected half-bit has been popped
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [dffft_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [7:0]                   cfg_data = '0;
  logic                         push = 1'b0;
  logic                         full;
  logic                         kind = dffft_pkg::KIND_RAW;
  logic [7:0]                   address_byte = '0;
  logic [7:0]                   data_byte = '0;
  logic [7:0]                   level_percent = '0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic                         line_level;
  logic                         stop_period;
  logic                         last;

  // Shadow copy of the registers and the stored light level
  logic       pol_inv = 1'b0;
  logic [7:0] lvl_addr = dffft_pkg::RST_LEVEL_ADDR;
  logic [7:0] cmd_addr = dffft_pkg::RST_COMMAND_ADDR;
  logic [7:0] off_cmd = dffft_pkg::RST_OFF_CMD;
  logic [7:0] on_cmd = dffft_pkg::RST_ON_CMD;
  logic [7:0] stored_level = dffft_pkg::LEVEL_OFF;

  half_bit_t half_bit_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count = 0;
  int unsigned requests_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;

  dali_forward_frame_transmitter_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .address_byte (address_byte),
    .data_byte    (data_byte),
    .level_percent(level_percent),
    .empty        (empty),
    .pop          (pop),
    .line_level   (line_level),
    .stop_period  (stop_period),
    .last         (last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Queue the 35 half-bit levels of one forward frame: start one, 16 bits MSB first, stop
  function automatic void queue_frame(logic [7:0] first, logic [7:0] second);
    logic [dffft_pkg::FRAME_BITS-1:0] word;
    logic                             lead;
    word = {1'b1, first, second};
    for (int i = dffft_pkg::FRAME_BITS - 1; i >= 0; i--) begin
      // one = low then high, zero = high then low, before inversion
      lead = ~word[i] ^ pol_inv;
      half_bit_q.push_back('{lead, 1'b0, 1'b0});
      half_bit_q.push_back('{~lead, 1'b0, 1'b0});
    end
    half_bit_q.push_back('{~pol_inv, 1'b1, 1'b1});
    frames_sent++;
  endfunction

  // Work out the frame (if any) that one accepted request causes
  function automatic void predict_request(logic k, logic [7:0] a, logic [7:0] d,
                                          logic [7:0] pct);
    int unsigned scaled;
    if (k == dffft_pkg::KIND_RAW) begin
      queue_frame(a, d);
      return;
    end
    if (pct > dffft_pkg::PCT_MAX) return;
    scaled = 32'(pct) * 32'(dffft_pkg::LEVEL_ON) / 32'(dffft_pkg::PCT_MAX);
    if (scaled == 32'(stored_level)) return;
    if (scaled < 32'(dffft_pkg::LEVEL_LOW)) begin
      stored_level = dffft_pkg::LEVEL_OFF;
      queue_frame(cmd_addr, off_cmd);
    end else if (scaled > 32'(dffft_pkg::LEVEL_HI)) begin
      stored_level = dffft_pkg::LEVEL_ON;
      queue_frame(cmd_addr, on_cmd);
    end else begin
      stored_level = scaled[7:0];
      queue_frame(lvl_addr, scaled[7:0]);
    end
  endfunction

  // Present one request with random lead-in idling; returns at the falling edge after accept
  task automatic send_request(logic k, logic [7:0] a, logic [7:0] d, logic [7:0] pct);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push          <= 1'b1;
    kind          <= k;
    address_byte  <= a;
    data_byte     <= d;
    level_percent <= pct;
    do @(posedge clk); while (full);
    predict_request(k, a, d, pct);
    requests_sent++;
    @(negedge clk);
  endtask

  // Stop sending and wait until every queued half-bit has been popped and the block settles
  task automatic drain_frames();
    push <= 1'b0;
    while (half_bit_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write on an idle block
  task automatic write_reg(logic [dffft_pkg::CFG_IW-1:0] idx, logic [7:0] val);
    drain_frames();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dffft_pkg::CFG_POLARITY:     pol_inv = val[0];
      dffft_pkg::CFG_LEVEL_ADDR:   lvl_addr = val;
      dffft_pkg::CFG_COMMAND_ADDR: cmd_addr = val;
      dffft_pkg::CFG_OFF_CMD:      off_cmd = val;
      dffft_pkg::CFG_ON_CMD:       on_cmd = val;
      default: ;  // unused index: ignored
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Level scaling around the off / arc / on thresholds, unchanged levels, rejects
  task automatic test_level_thresholds();
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd0);    // equals stored level: nothing
    send_request(dffft_pkg::KIND_LEVEL, 8'hFF, 8'hFF, 8'd100);  // full on
    send_request(dffft_pkg::KIND_LEVEL, 8'h12, 8'h34, 8'd100);  // unchanged
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'hFF, 8'd99);   // 252, still on
    send_request(dffft_pkg::KIND_LEVEL, 8'hFF, 8'h00, 8'd98);   // 249, highest arc power
    send_request(dffft_pkg::KIND_LEVEL, 8'h5A, 8'hA5, 8'd10);   // 25, lowest arc power
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd9);    // 22, off
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd1);    // 2, off again
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd0);    // 0 equals stored 0
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd101);  // rejected
    send_request(dffft_pkg::KIND_LEVEL, 8'hFF, 8'hFF, 8'd255);  // rejected
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd128);  // rejected
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd50);   // 127
  endtask

  // Raw frames at byte extremes and alternating patterns; level field is don't-care
  task automatic test_raw_frames();
    send_request(dffft_pkg::KIND_RAW, 8'h00, 8'h00, 8'd255);
    send_request(dffft_pkg::KIND_RAW, 8'hFF, 8'hFF, 8'd0);
    send_request(dffft_pkg::KIND_RAW, 8'hAA, 8'h55, 8'd50);
    send_request(dffft_pkg::KIND_RAW, 8'h55, 8'hAA, 8'd101);
    send_request(dffft_pkg::KIND_RAW, 8'h80, 8'h01, 8'd100);
  endtask

  // Register extremes, inverted polarity and writes to unused indexes
  task automatic test_registers();
    write_reg(dffft_pkg::CFG_POLARITY, 8'h01);
    write_reg(dffft_pkg::CFG_LEVEL_ADDR, 8'h00);
    write_reg(dffft_pkg::CFG_COMMAND_ADDR, 8'h00);
    write_reg(dffft_pkg::CFG_OFF_CMD, 8'hFF);
    write_reg(dffft_pkg::CFG_ON_CMD, 8'hFF);
    send_request(dffft_pkg::KIND_RAW, 8'hA5, 8'h5A, 8'd0);
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd100);
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd0);
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd40);
    // writes past the last register must leave all registers alone
    for (int k = dffft_pkg::CFG_ON_CMD + 1; k < 2 ** dffft_pkg::CFG_IW; k++) begin
      write_reg(dffft_pkg::CFG_IW'(k), 8'hFF);
    end
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd100);
    write_reg(dffft_pkg::CFG_POLARITY, 8'h00);
    write_reg(dffft_pkg::CFG_LEVEL_ADDR, 8'hFF);
    write_reg(dffft_pkg::CFG_COMMAND_ADDR, 8'hFF);
    write_reg(dffft_pkg::CFG_OFF_CMD, 8'h00);
    write_reg(dffft_pkg::CFG_ON_CMD, 8'h00);
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd0);
    send_request(dffft_pkg::KIND_LEVEL, 8'h00, 8'h00, 8'd70);
  endtask

  // Random registers, then a random mix of raw, level and rejected requests
  task automatic test_random(int unsigned s_idle, int unsigned r_idle, int unsigned count);
    int unsigned pick;
    logic [7:0]  pct;
    logic        k;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    write_reg(dffft_pkg::CFG_POLARITY, 8'($urandom_range(1)));
    write_reg(dffft_pkg::CFG_LEVEL_ADDR, 8'($urandom));
    write_reg(dffft_pkg::CFG_COMMAND_ADDR, 8'($urandom));
    write_reg(dffft_pkg::CFG_OFF_CMD, 8'($urandom));
    write_reg(dffft_pkg::CFG_ON_CMD, 8'($urandom));
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 90) pct = 8'($urandom_range(dffft_pkg::PCT_MAX));
      else pct = 8'($urandom_range(255, dffft_pkg::PCT_MAX + 1));
      k = (pick < 35) ? dffft_pkg::KIND_RAW : dffft_pkg::KIND_LEVEL;
      send_request(k, 8'($urandom), 8'($urandom), pct);
    end
  endtask

  // Receiver: random pop stalls
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each popped result with the oldest expected half-bit
  always @(posedge clk) begin
    half_bit_t got;
    half_bit_t want;
    if (!rst && pop && !empty) begin
      got = '{line_level, stop_period, last};
      if (half_bit_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, actual level=%b stop=%b last=%b",
                 $time, got.line_level, got.stop_period, got.last);
      end else begin
        want = half_bit_q.pop_front();
        results_checked++;
        if (got !== want) begin
          fail_count++;
          $display("%0t: mismatch: expected level=%b stop=%b last=%b,",
                   $time, want.line_level, want.stop_period, want.last,
                   " actual level=%b stop=%b last=%b",
                   got.line_level, got.stop_period, got.last);
        end
      end
    end
  end

  // Main sequence
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 29;
    recv_idle_pct = 71;
    test_level_thresholds();
    test_raw_frames();
    test_registers();
    test_random(29, 71, 135);
    test_random(71, 29, 135);
    test_random(0, 0, 135);
    drain_frames();
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    $display("Run covered %0d requests, %0d frames and %0d checked half-bits,",
             requests_sent, frames_sent, results_checked);
    $display("with %0d register writes over three idle patterns; %0d left unmatched",
             reg_writes, half_bit_q.size());
    if (fail_count == 0 && half_bit_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Timeout with %0d half-bits still expected", half_bit_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: files.f
hdl/dffft_pkg.sv
hdl/dffft_front.sv
hdl/dffft_queue.sv
hdl/dffft_serializer.sv
hdl/dali_forward_frame_transmitter_unit.sv
hdl/dffft_checker.sv
tb/tb_dali_forward_frame_transmitter.sv
